>>> rtl/xxh64lc_pkg.sv
// Shared constants and request/response types for the lower-case xxHash64 block.
package xxh64lc_pkg;

	localparam logic [63:0] PRIME1 = 64'd11400714785074694791;
	localparam logic [63:0] PRIME2 = 64'd14029467366897019727;
	localparam logic [63:0] PRIME3 = 64'd1609587929392839161;
	localparam logic [63:0] PRIME4 = 64'd9650029242287828579;
	localparam logic [63:0] PRIME5 = 64'd2870177450012600261;

	// Request to the shared multiplier: operands are sampled when start is high.
	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] b;
	} mul_req_t;

	// Response: p holds the low 64 bits of a*b in the cycle done is high.
	typedef struct packed {
		logic        done;
		logic [63:0] p;
	} mul_rsp_t;

endpackage

>>> rtl/xxh64_lowercase_hash.sv
// Top level: streaming xxHash64 of a lower-cased byte message, one shared multiplier.
//
//  channel  | handshake            | payload                              | dir
//  ---------+----------------------+--------------------------------------+-----
//  in       | in_valid / in_stall  | data_bytes[63:0] byte_count[3:0] last | in
//  out      | out_valid/ out_stall | hash_value[63:0]                     | out
//  seed cfg | seed_wr_en           | seed_wr_data[63:0]                   | in
//
// Every multiply goes through the one shared unit: it is started, the unit runs its 32x32
// passes, and the product returns with done. A word that only fills the stripe buffer is
// taken without leaving idle; a word that closes a 32-byte stripe takes 8 multiplies. A
// last word adds 8 more if it closes a stripe itself, 12 for the merge if 32 bytes or
// more were hashed, 3 per buffered word, 2 for a 4-byte tail chunk, 2 per single tail
// byte and 2 for the avalanche.
// Reset (arst_n low) clears the sequencer, length and seed at once; no clearing pass.
// in_stall stays high while a word is worked on; a finished hash waits in the output
// register and the next message is taken meanwhile.
module xxh64_lowercase_hash import xxh64lc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        seed_wr_en,
	input  logic [63:0] seed_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] data_bytes,
	input  logic [3:0]  byte_count,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] hash_value
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LR1,   // lane round, first half: x*PRIME2 plus base, rotate
		ST_LR2,   // lane round, second half: times PRIME1
		ST_HMIX,  // rotate hash (not in the merge), multiply, add constant (none for single tail bytes)
		ST_FIN,
		ST_SUM,
		ST_LEN,
		ST_T4,
		ST_T1,
		ST_AV1,
		ST_AV2,
		ST_DONE
	} state_t;

	// Which section of the computation the shared round states serve.
	typedef enum logic [2:0] {
		PH_STRIPE,
		PH_MERGE,
		PH_WORDS,
		PH_TAIL4,
		PH_TAIL1
	} phase_t;

	state_t      state_q;
	phase_t      ph_q;
	logic        pend_q;
	logic [1:0]  idx_q;
	logic [1:0]  slot_q;
	logic [63:0] byte_total_q;
	logic        last_q;
	logic [2:0]  n_q;
	logic        out_valid_q;
	logic [63:0] seed_q;

	logic [63:0] acc_q [4];
	logic [63:0] sw_q  [3];
	logic [63:0] w_q;
	logic [63:0] h_q;
	logic [63:0] t_q;
	logic [63:0] hash_q;

	logic        in_acc;
	logic        out_free;
	logic [3:0]  c_eff;
	logic [63:0] w_in;
	logic        push;
	logic        ge32;
	logic        mul_state;
	logic        mul_start;
	logic        mul_fin;
	mul_req_t    mreq;
	mul_rsp_t    mrsp;
	logic [63:0] lr_x;
	logic [63:0] lr_base;
	logic [63:0] lr1_val;
	logic [63:0] hmix_op;
	logic [63:0] hmix_k;
	logic [63:0] hmix_c;
	logic [63:0] sum_rot;
	logic [2:0]  n_after;
	state_t      tail_st;

	function automatic logic [63:0] rotl(input logic [63:0] v, input logic [5:0] r);
		return (v << r) | (v >> (7'd64 - {1'b0, r}));
	endfunction

	// Fold ASCII A..Z to lower case and drop bytes past the count.
	function automatic logic [63:0] fold_mask(input logic [63:0] v, input logic [3:0] c);
		logic [63:0] o;
		logic [7:0]  b;
		o = '0;
		for (int i = 0; i < 8; i++) begin
			b = v[8*i +: 8];
			if (b >= 8'h41 && b <= 8'h5A)
				b = b | 8'h20;
			if (4'(i) < c)
				o[8*i +: 8] = b;
		end
		return o;
	endfunction

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign hash_value = hash_q;
	assign out_free  = !out_valid_q || !out_stall;

	// A non-last word always carries eight bytes; a last word saturates at eight.
	always_comb begin
		if (!last)
			c_eff = 4'd8;
		else if (byte_count[3])
			c_eff = 4'd8;
		else
			c_eff = byte_count;
	end

	assign w_in = fold_mask(data_bytes, c_eff);
	assign push = !last || (c_eff == 4'd8);
	assign ge32 = |byte_total_q[63:5];

	assign mul_state = (state_q == ST_LR1) || (state_q == ST_LR2) || (state_q == ST_HMIX) ||
		(state_q == ST_T4) || (state_q == ST_T1) || (state_q == ST_AV1) ||
		(state_q == ST_AV2);
	assign mul_start = mul_state && !pend_q;
	assign mul_fin   = pend_q && mrsp.done;

	// Lane-round source word and base accumulator.
	always_comb begin
		case (ph_q)
			PH_STRIPE: lr_x = (idx_q == 2'd3) ? w_q : sw_q[idx_q];
			PH_MERGE:  lr_x = acc_q[idx_q];
			default:   lr_x = sw_q[idx_q];
		endcase
		lr_base = (ph_q == PH_STRIPE) ? acc_q[idx_q] : 64'd0;
	end

	assign lr1_val = rotl(lr_base + mrsp.p, 6'd31);

	always_comb begin
		case (ph_q)
			PH_MERGE: begin
				hmix_op = h_q;
				hmix_k  = PRIME1;
				hmix_c  = PRIME4;
			end
			PH_WORDS: begin
				hmix_op = rotl(h_q, 6'd27);
				hmix_k  = PRIME1;
				hmix_c  = PRIME4;
			end
			PH_TAIL4: begin
				hmix_op = rotl(h_q, 6'd23);
				hmix_k  = PRIME2;
				hmix_c  = PRIME3;
			end
			default: begin
				hmix_op = rotl(h_q, 6'd11);
				hmix_k  = PRIME1;
				hmix_c  = 64'd0;
			end
		endcase
	end

	always_comb begin
		case (idx_q)
			2'd0:    sum_rot = rotl(acc_q[0], 6'd1);
			2'd1:    sum_rot = rotl(acc_q[1], 6'd7);
			2'd2:    sum_rot = rotl(acc_q[2], 6'd12);
			default: sum_rot = rotl(acc_q[3], 6'd18);
		endcase
	end

	// Bytes still to mix once the current tail step is done, and where to go next.
	always_comb begin
		if (state_q == ST_HMIX && ph_q == PH_TAIL4)
			n_after = n_q - 3'd4;
		else if (state_q == ST_HMIX && ph_q == PH_TAIL1)
			n_after = n_q - 3'd1;
		else
			n_after = n_q;
		if (n_after[2])
			tail_st = ST_T4;
		else if (n_after != 3'd0)
			tail_st = ST_T1;
		else
			tail_st = ST_AV1;
	end

	always_comb begin
		mreq.start = mul_start;
		case (state_q)
			ST_LR1: begin
				mreq.a = lr_x;
				mreq.b = PRIME2;
			end
			ST_LR2: begin
				mreq.a = t_q;
				mreq.b = PRIME1;
			end
			ST_HMIX: begin
				mreq.a = hmix_op;
				mreq.b = hmix_k;
			end
			ST_T4: begin
				mreq.a = {32'b0, w_q[31:0]};
				mreq.b = PRIME1;
			end
			ST_T1: begin
				mreq.a = {56'b0, w_q[7:0]};
				mreq.b = PRIME5;
			end
			ST_AV1: begin
				mreq.a = h_q ^ (h_q >> 33);
				mreq.b = PRIME2;
			end
			ST_AV2: begin
				mreq.a = h_q;
				mreq.b = PRIME3;
			end
			default: begin
				mreq.a = h_q;
				mreq.b = PRIME1;
			end
		endcase
	end

	xxh64lc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	// Sequencer, length, seed and output handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			ph_q         <= PH_STRIPE;
			pend_q       <= 1'b0;
			idx_q        <= 2'd0;
			slot_q       <= 2'd0;
			byte_total_q <= 64'd0;
			last_q       <= 1'b0;
			n_q          <= 3'd0;
			out_valid_q  <= 1'b0;
			seed_q       <= 64'd0;
		end else begin
			if (seed_wr_en)
				seed_q <= seed_wr_data;
			// Load a finished hash, or drop valid once the word is taken.
			if (state_q == ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			if (mul_start)
				pend_q <= 1'b1;
			else if (mul_fin)
				pend_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						byte_total_q <= byte_total_q + {60'b0, c_eff};
						last_q       <= last;
						n_q          <= c_eff[2:0];
						if (push && slot_q != 2'd3) begin
							slot_q  <= slot_q + 2'd1;
							state_q <= last ? ST_FIN : ST_IDLE;
						end else if (push) begin
							ph_q    <= PH_STRIPE;
							idx_q   <= 2'd0;
							state_q <= ST_LR1;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_LR1: begin
					if (mul_fin)
						state_q <= ST_LR2;
				end
				ST_LR2: begin
					if (mul_fin) begin
						if (ph_q == PH_STRIPE) begin
							if (idx_q == 2'd3) begin
								slot_q  <= 2'd0;
								idx_q   <= 2'd0;
								state_q <= last_q ? ST_FIN : ST_IDLE;
							end else begin
								idx_q   <= idx_q + 2'd1;
								state_q <= ST_LR1;
							end
						end else begin
							state_q <= ST_HMIX;
						end
					end
				end
				ST_HMIX: begin
					if (mul_fin) begin
						case (ph_q)
							PH_MERGE: begin
								if (idx_q == 2'd3) begin
									idx_q   <= 2'd0;
									state_q <= ST_LEN;
								end else begin
									idx_q   <= idx_q + 2'd1;
									state_q <= ST_LR1;
								end
							end
							PH_WORDS: begin
								if (({1'b0, idx_q} + 3'd1) < {1'b0, slot_q}) begin
									idx_q   <= idx_q + 2'd1;
									state_q <= ST_LR1;
								end else begin
									state_q <= tail_st;
								end
							end
							default: begin
								n_q     <= n_after;
								state_q <= tail_st;
							end
						endcase
					end
				end
				ST_FIN: begin
					ph_q  <= PH_MERGE;
					idx_q <= 2'd0;
					state_q <= ge32 ? ST_SUM : ST_LEN;
				end
				ST_SUM: begin
					idx_q <= idx_q + 2'd1;
					if (idx_q == 2'd3)
						state_q <= ST_LR1;
				end
				ST_LEN: begin
					if (slot_q != 2'd0) begin
						ph_q    <= PH_WORDS;
						idx_q   <= 2'd0;
						state_q <= ST_LR1;
					end else begin
						state_q <= tail_st;
					end
				end
				ST_T4: begin
					if (mul_fin) begin
						ph_q    <= PH_TAIL4;
						state_q <= ST_HMIX;
					end
				end
				ST_T1: begin
					if (mul_fin) begin
						ph_q    <= PH_TAIL1;
						state_q <= ST_HMIX;
					end
				end
				ST_AV1: begin
					if (mul_fin)
						state_q <= ST_AV2;
				end
				ST_AV2: begin
					if (mul_fin)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					// Hold the hash until the output register frees up.
					if (out_free) begin
						byte_total_q <= 64'd0;
						slot_q       <= 2'd0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers: accumulators, stripe buffer, running hash.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					w_q <= w_in;
					// Load lanes from the seed at message start.
					if (byte_total_q == 64'd0) begin
						acc_q[0] <= seed_q + PRIME1 + PRIME2;
						acc_q[1] <= seed_q + PRIME2;
						acc_q[2] <= seed_q;
						acc_q[3] <= seed_q - PRIME1;
					end
					if (push && slot_q != 2'd3)
						sw_q[slot_q] <= w_in;
				end
			end
			ST_LR1: begin
				if (mul_fin)
					t_q <= lr1_val;
			end
			ST_LR2: begin
				if (mul_fin) begin
					if (ph_q == PH_STRIPE)
						acc_q[idx_q] <= mrsp.p;
					else
						h_q <= h_q ^ mrsp.p;
				end
			end
			ST_HMIX: begin
				if (mul_fin) begin
					h_q <= mrsp.p + hmix_c;
					if (ph_q == PH_TAIL4)
						w_q <= w_q >> 32;
					else if (ph_q == PH_TAIL1)
						w_q <= w_q >> 8;
				end
			end
			ST_FIN: begin
				if (!ge32)
					h_q <= seed_q + PRIME5;
			end
			ST_SUM: begin
				h_q <= ((idx_q == 2'd0) ? 64'd0 : h_q) + sum_rot;
			end
			ST_LEN: begin
				h_q <= h_q + byte_total_q;
			end
			ST_T4, ST_T1: begin
				if (mul_fin)
					h_q <= h_q ^ mrsp.p;
			end
			ST_AV1: begin
				if (mul_fin)
					h_q <= mrsp.p ^ (mrsp.p >> 29);
			end
			ST_AV2: begin
				if (mul_fin)
					h_q <= mrsp.p ^ (mrsp.p >> 32);
			end
			ST_DONE: begin
				if (out_free)
					hash_q <= h_q;
			end
			default: begin
				h_q <= h_q;
			end
		endcase
	end

	// No multiply may be outstanding while the block waits for a word.
	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pend_q)
		else $error("multiply outstanding in idle");

	// The multiplier answers only when the sequencer waits for it.
	a_done_when_pend: assert property (@(posedge clk) disable iff (!arst_n)
		mrsp.done |-> pend_q)
		else $error("unexpected multiplier response");

	// A finished hash moves to the output register once it is free.
	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free) |=> (out_valid_q && state_q == ST_IDLE))
		else $error("hash not handed to output");

	// A word that only fills the stripe buffer advances the slot count by one.
	a_slot_adv: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !last && slot_q != 2'd3) |=> (slot_q == $past(slot_q) + 2'd1))
		else $error("stripe slot did not advance");

endmodule

>>> rtl/xxh64lc_mul.sv
// Shared 64x64 (low half) multiplier built from one 32x32 multiplier, used in turn for each partial product.
module xxh64lc_mul import xxh64lc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mul_req_t req,
	output mul_rsp_t rsp
);

	logic [63:0] a_q;
	logic [63:0] b_q;
	logic [63:0] prod_q;
	logic [63:0] sum_q;
	logic [1:0]  phase_q;
	logic        busy_q;
	logic        done_q;
	logic [31:0] mx;
	logic [31:0] my;
	logic [63:0] prod_d;

	// Low*low, then the two cross terms; the high*high term falls off the top.
	always_comb begin
		case (phase_q)
			2'd0: begin
				mx = a_q[31:0];
				my = b_q[31:0];
			end
			2'd1: begin
				mx = a_q[31:0];
				my = b_q[63:32];
			end
			default: begin
				mx = a_q[63:32];
				my = b_q[31:0];
			end
		endcase
	end

	assign prod_d = {32'b0, mx} * {32'b0, my};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= 2'd0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q  <= 1'b1;
				phase_q <= 2'd0;
			end else if (busy_q) begin
				phase_q <= phase_q + 2'd1;
				if (phase_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			b_q <= req.b;
		end else if (busy_q) begin
			case (phase_q)
				2'd0: begin
					prod_q <= prod_d;
				end
				2'd1: begin
					sum_q  <= prod_q;
					prod_q <= prod_d;
				end
				2'd2: begin
					sum_q  <= sum_q + {prod_q[31:0], 32'b0};
					prod_q <= prod_d;
				end
				default: begin
					sum_q <= sum_q + {prod_q[31:0], 32'b0};
				end
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.p    = sum_q;

endmodule
